// ===== rtl/mrma_pkg.sv =====
// ----------------------------------------------------------------------------
// mrma_pkg
// Shared types and default constants for the rectified moving-average
// envelope block: controller states, command and status bundles.
// ----------------------------------------------------------------------------
package mrma_pkg;

    localparam int DEF_PEAK_DEPTH  = 5;
    localparam int DEF_AVG_DEPTH   = 25;
    localparam int DEF_SAMPLE_BITS = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BASE,
        ST_MID,
        ST_ACC,
        ST_MUL,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_rd;
        logic mid;
        logic acc;
        logic mul;
        logic load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/mrma_ram.sv =====
// ----------------------------------------------------------------------------
// mrma_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mrma_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mrma_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrma_ctrl
// Sequencer for one sample: capture, window scan, baseline and rectify,
// running sum update, reciprocal multiply, result load.
// ----------------------------------------------------------------------------
module mrma_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mrma_pkg::status_t status,
    output mrma_pkg::cmd_t    cmd
);

    import mrma_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE: state_next = ST_MID;
            ST_MID:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_SCAN: cmd.scan_rd = 1'b1;
            ST_BASE: cmd = '0;
            ST_MID:  cmd.mid = 1'b1;
            ST_ACC:  cmd.acc = 1'b1;
            ST_MUL:  cmd.mul = 1'b1;
            ST_DONE: cmd.load = status.out_free;
            default: cmd = '0;
        endcase
    end

    // only one datapath step per cycle
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.scan_rd, cmd.mid, cmd.acc, cmd.mul, cmd.load}))
        else $error("more than one datapath command active");

endmodule

// ===== rtl/mrma_dpath.sv =====
// ----------------------------------------------------------------------------
// mrma_dpath
// Datapath: peak window memory with min/max scan, baseline and rectifier,
// averaging window memory with running sum, reciprocal divide, output beat.
// ----------------------------------------------------------------------------
module mrma_dpath #(
    parameter int PEAK_DEPTH  = mrma_pkg::DEF_PEAK_DEPTH,
    parameter int AVG_DEPTH   = mrma_pkg::DEF_AVG_DEPTH,
    parameter int SAMPLE_BITS = mrma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mrma_pkg::cmd_t         cmd,
    output mrma_pkg::status_t      status,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] envelope,
    output logic [SAMPLE_BITS-1:0] baseline,
    output logic [SAMPLE_BITS-1:0] rectified
);

    import mrma_pkg::*;

    localparam int PAW       = $clog2(PEAK_DEPTH);
    localparam int PFW       = $clog2(PEAK_DEPTH + 1);
    localparam int AAW       = $clog2(AVG_DEPTH);
    localparam int AFW       = $clog2(AVG_DEPTH + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(AVG_DEPTH);
    localparam int DIV_SHIFT = SUM_BITS + $clog2(AVG_DEPTH);
    localparam int PROD_W    = 2 * SUM_BITS + 1;
    localparam longint unsigned RECIP_L =
        ((64'd1 << DIV_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [SUM_BITS:0] RECIP = (SUM_BITS + 1)'(RECIP_L);

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] hi_reg;
    logic [SAMPLE_BITS-1:0] lo_reg;
    logic [SAMPLE_BITS-1:0] base_reg;
    logic [SAMPLE_BITS-1:0] rect_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PFW-1:0]         peak_fill_reg;
    logic [PAW-1:0]         peak_slot_reg;
    logic [PFW-1:0]         scan_cnt_reg;
    logic                   scan_valid_reg;
    logic [AFW-1:0]         avg_fill_reg;
    logic [AAW-1:0]         avg_slot_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] env_out_reg;
    logic [SAMPLE_BITS-1:0] base_out_reg;
    logic [SAMPLE_BITS-1:0] rect_out_reg;

    logic [SAMPLE_BITS-1:0] peak_rd_data;
    logic [SAMPLE_BITS-1:0] avg_rd_data;
    logic [SAMPLE_BITS:0]   mid_sum;
    logic [SAMPLE_BITS-1:0] base_calc;
    logic [SAMPLE_BITS-1:0] rect_calc;
    logic                   avg_full;
    logic [SUM_BITS-1:0]    sum_next;

    mrma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (PEAK_DEPTH)
    ) u_peak_ram (
        .clk     (clk),
        .wr_en   (cmd.capture),
        .wr_addr (peak_slot_reg),
        .wr_data (sample),
        .rd_en   (cmd.scan_rd),
        .rd_addr (scan_cnt_reg[PAW-1:0]),
        .rd_data (peak_rd_data)
    );

    mrma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (AVG_DEPTH)
    ) u_avg_ram (
        .clk     (clk),
        .wr_en   (cmd.acc),
        .wr_addr (avg_slot_reg),
        .wr_data (rect_reg),
        .rd_en   (cmd.mid),
        .rd_addr (avg_slot_reg),
        .rd_data (avg_rd_data)
    );

    assign mid_sum   = {1'b0, hi_reg} + {1'b0, lo_reg};
    assign base_calc = mid_sum[SAMPLE_BITS:1];
    assign rect_calc = (sample_reg >= base_calc) ? (sample_reg - base_calc)
                                                 : (base_calc - sample_reg);
    assign avg_full  = (avg_fill_reg == AFW'(AVG_DEPTH));
    // oldest value leaves the sum once the window is full
    assign sum_next  = sum_reg - (avg_full ? SUM_BITS'(avg_rd_data) : '0)
                     + SUM_BITS'(rect_reg);

    assign status.scan_last = (scan_cnt_reg == peak_fill_reg - PFW'(1));
    assign status.out_free  = !out_valid_reg || !out_stall;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_fill_reg  <= '0;
            peak_slot_reg  <= '0;
            scan_cnt_reg   <= '0;
            scan_valid_reg <= 1'b0;
            avg_fill_reg   <= '0;
            avg_slot_reg   <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            scan_valid_reg <= cmd.scan_rd;
            if (cmd.capture)
            begin
                scan_cnt_reg  <= '0;
                peak_slot_reg <= (peak_slot_reg == PAW'(PEAK_DEPTH - 1)) ? '0
                               : peak_slot_reg + PAW'(1);
                if (peak_fill_reg != PFW'(PEAK_DEPTH))
                begin
                    peak_fill_reg <= peak_fill_reg + PFW'(1);
                end
            end
            else if (cmd.scan_rd)
            begin
                scan_cnt_reg <= scan_cnt_reg + PFW'(1);
            end
            if (cmd.acc)
            begin
                sum_reg      <= sum_next;
                avg_slot_reg <= (avg_slot_reg == AAW'(AVG_DEPTH - 1)) ? '0
                              : avg_slot_reg + AAW'(1);
                if (!avg_full)
                begin
                    avg_fill_reg <= avg_fill_reg + AFW'(1);
                end
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
            hi_reg     <= sample;
            lo_reg     <= sample;
        end
        else if (scan_valid_reg)
        begin
            if (peak_rd_data > hi_reg)
            begin
                hi_reg <= peak_rd_data;
            end
            if (peak_rd_data < lo_reg)
            begin
                lo_reg <= peak_rd_data;
            end
        end
        if (cmd.mid)
        begin
            base_reg <= base_calc;
            rect_reg <= rect_calc;
        end
        if (cmd.mul)
        begin
            // floor(sum / AVG_DEPTH) via exact reciprocal
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
        end
        if (cmd.load)
        begin
            env_out_reg  <= prod_reg[DIV_SHIFT +: SAMPLE_BITS];
            base_out_reg <= base_reg;
            rect_out_reg <= rect_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign envelope  = env_out_reg;
    assign baseline  = base_out_reg;
    assign rectified = rect_out_reg;

    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_rd |-> (scan_cnt_reg < peak_fill_reg))
        else $error("scan address beyond valid peak entries");

    a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (peak_fill_reg <= PFW'(PEAK_DEPTH)) && (avg_fill_reg <= AFW'(AVG_DEPTH)))
        else $error("window fill count out of range");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load))
        else $error("output beat raised without a load");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || !out_stall))
        else $error("pending output beat overwritten");

endmodule

// ===== rtl/midline_rectify_moving_average.sv =====
// ----------------------------------------------------------------------------
// midline_rectify_moving_average
// The min/max scan reads the valid peak window entries (at most PEAK_DEPTH)
// serially through the single read port of the peak memory, and a new sample
// is accepted only after the previous result has been loaded into the output
// register, which waits while a pending output beat is stalled.
// Reset clears fill counts, slots, running sum and handshake state; window
// memories are not cleared since only written entries are read.
// ----------------------------------------------------------------------------
module midline_rectify_moving_average #(
    parameter int PEAK_DEPTH  = mrma_pkg::DEF_PEAK_DEPTH,
    parameter int AVG_DEPTH   = mrma_pkg::DEF_AVG_DEPTH,
    parameter int SAMPLE_BITS = mrma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] envelope,
    output logic [SAMPLE_BITS-1:0] baseline,
    output logic [SAMPLE_BITS-1:0] rectified
);

    import mrma_pkg::*;

    cmd_t    cmd;
    status_t status;

    mrma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    mrma_dpath #(
        .PEAK_DEPTH  (PEAK_DEPTH),
        .AVG_DEPTH   (AVG_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .envelope  (envelope),
        .baseline  (baseline),
        .rectified (rectified)
    );

endmodule
